FILE: rtl/periodic_task_tick_scheduler_defines.svh
// Assertion macros for the periodic task tick scheduler.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PTTS_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define PTTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PTTS_ASSERT(lbl, expr, msg)
`define PTTS_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/ptts_pkg.sv
// Shared types and codes of the periodic task tick scheduler.
// No dependencies.
package ptts_pkg;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_CREATE  = 3'd1;
    localparam logic [2:0] OP_SUSPEND = 3'd2;
    localparam logic [2:0] OP_RESUME  = 3'd3;
    localparam logic [2:0] OP_DELETE  = 3'd4;

    localparam int SLOT_W  = 3;
    localparam int COUNT_W = 16;

    typedef struct packed {
        logic               create;
        logic               suspend;
        logic               resume;
        logic               remove;
        logic [COUNT_W-1:0] period;
        logic [COUNT_W-1:0] first_delay;
    } cell_cmd_t;

endpackage

FILE: rtl/periodic_task_tick_scheduler.sv
// Top level of the periodic task tick scheduler: command decode, scan control
// and result register over a chain of ptts_cell; depends on ptts_pkg.
//
// channel  handshake            fields
// request  req_valid/req_stall  op, slot, has_handler, period, first_delay
// result   res_valid/res_stall  task_slot, fired, status, stored, last
//
// Create, suspend, resume and delete each give one result.
// A tick moves a token down the cell chain one cell a cycle while the result
// side does not stall.
// Reset clears every slot at once; no clearing pass.
// A stalled result holds the scan in place.
`include "periodic_task_tick_scheduler_defines.svh"
module periodic_task_tick_scheduler
    import ptts_pkg::*;
#(
    parameter int TASK_COUNT = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         op,
    input  logic [SLOT_W-1:0]  slot,
    input  logic               has_handler,
    input  logic [COUNT_W-1:0] period,
    input  logic [COUNT_W-1:0] first_delay,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [SLOT_W-1:0]  task_slot,
    output logic               fired,
    output logic               status,
    output logic               stored,
    output logic               last
);

    localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [SLOT_W-1:0]   pend_slot_reg, pend_slot_next;
    logic                out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_fired_reg, out_fired_next;
    logic                out_status_reg, out_status_next;
    logic                out_stored_reg, out_stored_next;
    logic                out_last_reg, out_last_next;

    logic                out_free;
    logic                accept;
    logic                accept_tick;
    logic                step;
    logic                any_fire;
    logic                free_hit;
    cell_cmd_t           cmd;
    logic [TASK_COUNT-1:0] sel_vec;
    logic [TASK_COUNT-1:0] token_vec;
    logic [TASK_COUNT-1:0] fire_vec;
    logic [TASK_COUNT-1:0] handler_vec;

    assign out_free    = !out_valid_reg || !res_stall;
    assign req_stall   = (state_reg != ST_IDLE) || !out_free;
    assign accept      = req_valid && !req_stall;
    assign accept_tick = accept && (op == OP_TICK);
    assign step        = accept_tick || ((state_reg == ST_SCAN) && out_free);
    assign any_fire    = |fire_vec;
    assign free_hit    = |(sel_vec & ~handler_vec);

    assign cmd.create      = accept && (op == OP_CREATE) && has_handler;
    assign cmd.suspend     = accept && (op == OP_SUSPEND);
    assign cmd.resume      = accept && (op == OP_RESUME);
    assign cmd.remove      = accept && (op == OP_DELETE);
    assign cmd.period      = period;
    assign cmd.first_delay = first_delay;

    genvar gi;
    generate
        for (gi = 0; gi < TASK_COUNT; gi++)
        begin : g_cell
            logic tok_in;
            if (gi == 0)
            begin : g_head
                assign tok_in = accept_tick;
            end
            else
            begin : g_link
                assign tok_in = token_vec[gi-1];
            end
            assign sel_vec[gi] = (int'(slot) == gi);
            ptts_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .sel       (sel_vec[gi]),
                .step      (step),
                .token_in  (tok_in),
                .token_out (token_vec[gi]),
                .fire      (fire_vec[gi]),
                .handler   (handler_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_slot_next  = pend_slot_reg;
        out_valid_next  = out_valid_reg && res_stall;
        out_slot_next   = out_slot_reg;
        out_fired_next  = out_fired_reg;
        out_status_next = out_status_reg;
        out_stored_next = out_stored_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_TICK)
                    begin
                        state_next = ST_SCAN;
                        idx_next   = '0;
                        pend_next  = 1'b0;
                    end
                    else if (op == OP_CREATE || op == OP_SUSPEND ||
                             op == OP_RESUME || op == OP_DELETE)
                    begin
                        out_valid_next  = 1'b1;
                        out_slot_next   = slot;
                        out_fired_next  = 1'b0;
                        out_status_next = (op == OP_CREATE) && !has_handler;
                        out_stored_next = (op == OP_CREATE) && has_handler && free_hit;
                        out_last_next   = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    if (any_fire)
                    begin
                        if (pend_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_slot_next   = pend_slot_reg;
                            out_fired_next  = 1'b1;
                            out_status_next = 1'b0;
                            out_stored_next = 1'b0;
                            out_last_next   = 1'b0;
                        end
                        pend_next      = 1'b1;
                        pend_slot_next = SLOT_W'(idx_reg);
                    end
                    idx_next = idx_reg + IDX_W'(1);
                    if (token_vec[TASK_COUNT-1])
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    if (pend_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_slot_next   = pend_slot_reg;
                        out_fired_next  = 1'b1;
                        out_status_next = 1'b0;
                        out_stored_next = 1'b0;
                        out_last_next   = 1'b1;
                    end
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg  <= pend_slot_next;
        out_slot_reg   <= out_slot_next;
        out_fired_reg  <= out_fired_next;
        out_status_reg <= out_status_next;
        out_stored_reg <= out_stored_next;
        out_last_reg   <= out_last_next;
    end

    assign res_valid = out_valid_reg;
    assign task_slot = out_slot_reg;
    assign fired     = out_fired_reg;
    assign status    = out_status_reg;
    assign stored    = out_stored_reg;
    assign last      = out_last_reg;

    `PTTS_ASSERT(a_token_single, $onehot0(token_vec), "more than one scan token")
    `PTTS_ASSERT(a_fire_single, $onehot0(fire_vec), "more than one cell firing")
    `PTTS_ASSERT_IMP(a_scan_token, state_reg == ST_SCAN, token_vec != '0, "scan lost its token")
    `PTTS_ASSERT_IMP(a_idle_token, state_reg != ST_SCAN, token_vec == '0, "token outside scan")
    `PTTS_ASSERT_IMP(a_busy_stall, state_reg != ST_IDLE, req_stall, "request taken while busy")

endmodule

FILE: rtl/ptts_cell.sv
// One task slot: handler, suspend flag, period and countdown.
// Passes the scan token to its neighbor; depends on ptts_pkg.
module ptts_cell
    import ptts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  logic      sel,
    input  logic      step,
    input  logic      token_in,
    output logic      token_out,
    output logic      fire,
    output logic      handler
);

    logic               token_reg;
    logic               handler_reg;
    logic               susp_reg;
    logic [COUNT_W-1:0] period_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               active;

    assign active    = token_reg && step && !susp_reg;
    assign token_out = token_reg;
    assign fire      = token_reg && !susp_reg && handler_reg && (count_reg == '0);
    assign handler   = handler_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg   <= 1'b0;
            handler_reg <= 1'b0;
            susp_reg    <= 1'b0;
            period_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (step)
            begin
                token_reg <= token_in;
            end
            if (active)
            begin
                if (count_reg == '0)
                begin
                    count_reg <= period_reg - COUNT_W'(1);
                end
                else
                begin
                    count_reg <= count_reg - COUNT_W'(1);
                end
            end
            if (sel)
            begin
                if (cmd.create && !handler_reg)
                begin
                    handler_reg <= 1'b1;
                    susp_reg    <= 1'b0;
                    period_reg  <= cmd.period;
                    count_reg   <= cmd.first_delay;
                end
                if (cmd.suspend)
                begin
                    susp_reg <= 1'b1;
                end
                if (cmd.resume)
                begin
                    susp_reg <= 1'b0;
                end
                if (cmd.remove)
                begin
                    handler_reg <= 1'b0;
                end
            end
        end
    end

endmodule
